// ===== src/avcd_pkg.sv =====
// ----------------------------------------------------------------------------
// avcd_pkg: shared types for the vertex collision detector
// Field widths, per-agent cell records and the items that travel between
// pipeline stages.
// ----------------------------------------------------------------------------
package avcd_pkg;

  localparam int unsigned MaxAgents = 4;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned StepOutW  = 16;
  localparam int unsigned GroupCnt  = 2;

  typedef logic [CoordW-1:0]    coord_t;
  typedef logic [MaxAgents-1:0] agent_mask_t;
  typedef logic [StepOutW-1:0]  step_t;
  typedef logic [1:0]           grp_cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } cell_t;

  typedef cell_t [MaxAgents-1:0] cell_arr_t;

  // eq[j][k] set when agents j and k stand on the same cell
  typedef agent_mask_t [MaxAgents-1:0] eq_mat_t;

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    agent_mask_t mask;
  } group_t;

  typedef struct packed {
    cell_arr_t   cells;
    agent_mask_t present;
    step_t       step;
  } step_item_t;

  typedef struct packed {
    cell_arr_t   cells;
    agent_mask_t present;
    step_t       step;
    eq_mat_t     eq;
  } match_item_t;

  typedef struct packed {
    group_t [GroupCnt-1:0] grp;
    grp_cnt_t              count;
    step_t                 step;
  } group_item_t;

endpackage

// ===== src/avcd_match.sv =====
// ----------------------------------------------------------------------------
// avcd_match: pairwise cell compare stage
// Compares the cells of every agent pair and registers the match matrix
// together with the step item.
// ----------------------------------------------------------------------------
module avcd_match (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  avcd_pkg::step_item_t     in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output avcd_pkg::match_item_t    out_item_o
);
  import avcd_pkg::*;

  logic        valid_q;
  match_item_t item_q;
  eq_mat_t     eq_d;

  always_comb begin
    for (int j = 0; j < MaxAgents; j++) begin
      for (int k = 0; k < MaxAgents; k++) begin
        eq_d[j][k] = (in_item_i.cells[j] == in_item_i.cells[k]);
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.cells   <= in_item_i.cells;
      item_q.present <= in_item_i.present;
      item_q.step    <= in_item_i.step;
      item_q.eq      <= eq_d;
    end
  end

endmodule

// ===== src/avcd_group.sv =====
// ----------------------------------------------------------------------------
// avcd_group: group extraction stage
// Finds the lead agent of each shared cell, builds the group masks and keeps
// the first two groups of two or more agents. Steps without a group drop here.
// ----------------------------------------------------------------------------
module avcd_group (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  avcd_pkg::match_item_t    in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output avcd_pkg::group_item_t    out_item_o
);
  import avcd_pkg::*;

  logic        valid_q;
  group_item_t item_q;
  group_item_t item_d;

  agent_mask_t             lead;
  agent_mask_t             shared;
  agent_mask_t [MaxAgents-1:0] mask;

  always_comb begin
    lead   = '0;
    shared = '0;
    item_d = '0;
    for (int j = 0; j < MaxAgents; j++) begin
      logic prior;
      prior = 1'b0;
      for (int k = 0; k < j; k++) begin
        prior = prior | (in_item_i.present[k] & in_item_i.eq[k][j]);
      end
      lead[j]   = in_item_i.present[j] & !prior;
      mask[j]   = in_item_i.present & in_item_i.eq[j];
      shared[j] = lead[j] && ((mask[j] & (mask[j] - 1'b1)) != '0);
    end
    item_d.step = in_item_i.step;
    for (int j = 0; j < MaxAgents; j++) begin
      if (shared[j]) begin
        if (item_d.count == grp_cnt_t'(0)) begin
          item_d.grp[0].x    = in_item_i.cells[j].x;
          item_d.grp[0].y    = in_item_i.cells[j].y;
          item_d.grp[0].mask = mask[j];
          item_d.count       = grp_cnt_t'(1);
        end else if (item_d.count == grp_cnt_t'(1)) begin
          item_d.grp[1].x    = in_item_i.cells[j].x;
          item_d.grp[1].y    = in_item_i.cells[j].y;
          item_d.grp[1].mask = mask[j];
          item_d.count       = grp_cnt_t'(2);
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i && (item_d.count != grp_cnt_t'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== src/avcd_emit.sv =====
// ----------------------------------------------------------------------------
// avcd_emit: ordering and result output stage
// Puts the two groups of a step in ascending x then y order and hands them
// out one result per transfer, marking the last one of the step.
// ----------------------------------------------------------------------------
module avcd_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  avcd_pkg::group_item_t    in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output avcd_pkg::step_t          step_index_o,
  output avcd_pkg::group_t         group_o,
  output logic                     last_o
);
  import avcd_pkg::*;

  logic   out_valid_q;
  logic   pend_valid_q;
  logic   last_q;
  step_t  step_q;
  group_t cur_q;
  group_t pend_q;

  logic   two;
  logic   swap;
  group_t first;
  group_t second;
  logic   out_fire;
  logic   in_fire;

  assign two = (in_item_i.count == grp_cnt_t'(2));
  assign swap = two && ((in_item_i.grp[1].x < in_item_i.grp[0].x) ||
                        ((in_item_i.grp[1].x == in_item_i.grp[0].x) &&
                         (in_item_i.grp[1].y < in_item_i.grp[0].y)));
  assign first  = swap ? in_item_i.grp[1] : in_item_i.grp[0];
  assign second = swap ? in_item_i.grp[0] : in_item_i.grp[1];

  assign out_fire   = out_valid_q && out_ready_i;
  assign in_ready_o = !out_valid_q || (out_fire && !pend_valid_q);
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o  = out_valid_q;
  assign step_index_o = step_q;
  assign group_o      = cur_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= two;
    end else if (out_fire) begin
      out_valid_q  <= pend_valid_q;
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      step_q <= in_item_i.step;
      cur_q  <= first;
      pend_q <= second;
      last_q <= !two;
    end else if (out_fire && pend_valid_q) begin
      cur_q  <= pend_q;
      last_q <= 1'b1;
    end
  end

endmodule

// ===== src/agent_vertex_collision_detect_top.sv =====
// ----------------------------------------------------------------------------
// agent_vertex_collision_detect_top: vertex collision detector for grid agents
// Reports every cell that two or more present agents share at a time step.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i/in_ready_o  | agent0..3 x/y, present_mask, final_step
//   out     | out_valid_o/out_ready_i| step_index, cell_x/y, involved_mask, last
//
// Three register stages: pair compare, group extraction, ordering/output.
// Steps with one or no collision flow at one per cycle while out_ready_i is
// high; a step with two collisions holds the ordering/output stage until
// both its results are taken, set by the single result port.
// Reset clears valid bits and the step counter; stalls hold every stage.
// ----------------------------------------------------------------------------
module agent_vertex_collision_detect_top #(
  parameter int unsigned NUM_AGENTS = 4,
  parameter int unsigned COORD_BITS = 8,
  parameter int unsigned STEP_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            agent0_x_i,
  input  logic [7:0]            agent0_y_i,
  input  logic [7:0]            agent1_x_i,
  input  logic [7:0]            agent1_y_i,
  input  logic [7:0]            agent2_x_i,
  input  logic [7:0]            agent2_y_i,
  input  logic [7:0]            agent3_x_i,
  input  logic [7:0]            agent3_y_i,
  input  logic [3:0]            present_mask_i,
  input  logic                  final_step_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           step_index_o,
  output logic [7:0]            cell_x_o,
  output logic [7:0]            cell_y_o,
  output logic [3:0]            involved_mask_o,
  output logic                  last_of_step_o
);
  import avcd_pkg::*;

  localparam int unsigned CmpBits = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam coord_t      CoordMask = coord_t'((1 << CmpBits) - 1);
  localparam agent_mask_t AgentMask = agent_mask_t'((1 << NUM_AGENTS) - 1);
  localparam logic [STEP_BITS-1:0] StepMax = '1;

  logic [STEP_BITS-1:0]          step_cnt_q;
  logic [STEP_BITS-1:0]          step_cnt_d;
  logic [STEP_BITS+StepOutW-1:0] step_ext;

  step_item_t  in_item;
  logic        match_valid;
  logic        match_ready;
  match_item_t match_item;
  logic        group_valid;
  logic        group_ready;
  group_item_t group_item;
  group_t      res_group;
  step_t       res_step;

  assign step_ext = {{StepOutW{1'b0}}, step_cnt_q};

  always_comb begin
    in_item.cells[0].x = agent0_x_i & CoordMask;
    in_item.cells[0].y = agent0_y_i & CoordMask;
    in_item.cells[1].x = agent1_x_i & CoordMask;
    in_item.cells[1].y = agent1_y_i & CoordMask;
    in_item.cells[2].x = agent2_x_i & CoordMask;
    in_item.cells[2].y = agent2_y_i & CoordMask;
    in_item.cells[3].x = agent3_x_i & CoordMask;
    in_item.cells[3].y = agent3_y_i & CoordMask;
    in_item.present    = present_mask_i & AgentMask;
    in_item.step       = step_ext[StepOutW-1:0];
  end

  always_comb begin
    step_cnt_d = step_cnt_q;
    if (final_step_i) begin
      step_cnt_d = '0;
    end else if (step_cnt_q != StepMax) begin
      step_cnt_d = step_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cnt_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      step_cnt_q <= step_cnt_d;
    end
  end

  avcd_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (match_valid),
    .out_ready_i (match_ready),
    .out_item_o  (match_item)
  );

  avcd_group u_group (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (match_valid),
    .in_ready_o  (match_ready),
    .in_item_i   (match_item),
    .out_valid_o (group_valid),
    .out_ready_i (group_ready),
    .out_item_o  (group_item)
  );

  avcd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (group_valid),
    .in_ready_o   (group_ready),
    .in_item_i    (group_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .step_index_o (res_step),
    .group_o      (res_group),
    .last_o       (last_of_step_o)
  );

  assign step_index_o    = res_step;
  assign cell_x_o        = res_group.x;
  assign cell_y_o        = res_group.y;
  assign involved_mask_o = res_group.mask;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for agent_vertex_collision_detect_top
// A table of directed steps is walked first, followed by random steps
// biased toward shared cells. Every collision report is compared field by
// field, in order, with a typed-in report or a behavioral prediction. Both
// handshakes idle at random outside a calm stretch of the random steps.
// ----------------------------------------------------------------------------
module tb;

  import avcd_pkg::*;

  typedef struct packed {
    cell_t [3:0] pos;
    agent_mask_t present;
    logic        final_step;
  } step_in_t;

  typedef struct packed {
    step_t       step;
    coord_t      x;
    coord_t      y;
    agent_mask_t mask;
    logic        last;
  } hit_t;

  // n < 0: check against the prediction; otherwise n typed-in reports
  typedef struct {
    step_in_t s;
    int       n;
    hit_t     e0;
    hit_t     e1;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  step_in_t    in_step = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  step_t       step_index;
  coord_t      cell_x;
  coord_t      cell_y;
  agent_mask_t involved_mask;
  logic        last_of_step;

  hit_t     hit_q[$];
  step_t    pred_step = '0;
  int       errors = 0;
  bit       calm = 1'b0;
  dir_row_t rows[$];

  agent_vertex_collision_detect_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .agent0_x_i      (in_step.pos[0].x),
    .agent0_y_i      (in_step.pos[0].y),
    .agent1_x_i      (in_step.pos[1].x),
    .agent1_y_i      (in_step.pos[1].y),
    .agent2_x_i      (in_step.pos[2].x),
    .agent2_y_i      (in_step.pos[2].y),
    .agent3_x_i      (in_step.pos[3].x),
    .agent3_y_i      (in_step.pos[3].y),
    .present_mask_i  (in_step.present),
    .final_step_i    (in_step.final_step),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .step_index_o    (step_index),
    .cell_x_o        (cell_x),
    .cell_y_o        (cell_y),
    .involved_mask_o (involved_mask),
    .last_of_step_o  (last_of_step)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Append one expected report.
  function automatic void add_hit(input hit_t h);
    hit_q.insert(hit_q.size(), h);
  endfunction

  // Append one directed row.
  function automatic void add_row(input dir_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // Group present agents by cell, report shared cells in x then y order.
  function automatic void predict_hits(input step_in_t s, input bit push);
    agent_mask_t done;
    agent_mask_t m;
    hit_t        g[2];
    hit_t        t;
    int          ng;
    done = '0;
    ng   = 0;
    for (int j = 0; j < 4; j++) begin
      if (!s.present[j] || done[j]) continue;
      m = '0;
      for (int k = 0; k < 4; k++) begin
        if (s.present[k] && s.pos[k] == s.pos[j]) m[k] = 1'b1;
      end
      done |= m;
      if ($countones(m) >= 2 && ng < 2) begin
        g[ng].step = pred_step;
        g[ng].x    = s.pos[j].x;
        g[ng].y    = s.pos[j].y;
        g[ng].mask = m;
        g[ng].last = 1'b0;
        ng++;
      end
    end
    if (ng == 2 && (g[1].x < g[0].x || (g[1].x == g[0].x && g[1].y < g[0].y))) begin
      t    = g[0];
      g[0] = g[1];
      g[1] = t;
    end
    for (int k = 0; k < ng; k++) begin
      g[k].last = (k == ng - 1);
      if (push) add_hit(g[k]);
    end
    if (s.final_step) pred_step = '0;
    else if (pred_step != '1) pred_step = pred_step + 1'b1;
  endfunction

  function automatic step_in_t mk_step(input coord_t x0, y0, x1, y1, x2, y2, x3, y3,
                                       input agent_mask_t present, input logic fin);
    step_in_t s;
    s.pos[0]     = '{x: x0, y: y0};
    s.pos[1]     = '{x: x1, y: y1};
    s.pos[2]     = '{x: x2, y: y2};
    s.pos[3]     = '{x: x3, y: y3};
    s.present    = present;
    s.final_step = fin;
    return s;
  endfunction

  function automatic hit_t mk_hit(input step_t st, input coord_t x, y,
                                  input agent_mask_t mask, input logic last);
    hit_t h;
    h.step = st;
    h.x    = x;
    h.y    = y;
    h.mask = mask;
    h.last = last;
    return h;
  endfunction

  function automatic dir_row_t mk_row(input step_in_t s, input int n, input hit_t e0, e1);
    dir_row_t r;
    r.s  = s;
    r.n  = n;
    r.e0 = e0;
    r.e1 = e1;
    return r;
  endfunction

  // Draw agents mostly from two shared candidate cells, the rest anywhere.
  function automatic dir_row_t rand_row(input int final_pct, input int pool_pct);
    step_in_t s;
    cell_t    c0;
    cell_t    c1;
    c0 = cell_t'($urandom);
    c1 = cell_t'($urandom);
    if ($urandom_range(3) == 0) c1.x = c0.x;
    for (int j = 0; j < 4; j++) begin
      if ($urandom_range(99) < pool_pct) s.pos[j] = $urandom_range(1) ? c0 : c1;
      else s.pos[j] = cell_t'($urandom);
    end
    s.present    = $urandom_range(1) ? 4'hF : agent_mask_t'($urandom_range(15));
    s.final_step = ($urandom_range(99) < final_pct);
    return mk_row(s, -1, '0, '0);
  endfunction

  task automatic drive_step(input dir_row_t r);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_step  <= r.s;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_hits(r.s, r.n < 0);
    if (r.n > 0) add_hit(r.e0);
    if (r.n > 1) add_hit(r.e1);
    @(negedge clk_i);
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin : hit_monitor
    hit_t got;
    hit_t want;
    if (rst_ni && out_valid && out_ready) begin
      got = mk_hit(step_index, cell_x, cell_y, involved_mask, last_of_step);
      if (hit_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report: %p", got);
      end else begin
        want = hit_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: step %0d/%0d x %0d/%0d y %0d/%0d mask %b/%b last %b/%b",
                     want.step, got.step, want.x, got.x, want.y, got.y,
                     want.mask, got.mask, want.last, got.last);
          end
        end
      end
    end
  end

  initial begin
    int w;
    add_row(mk_row(mk_step(0, 0, 0, 0, 0, 0, 0, 0, 4'hF, 0), 1,
                   mk_hit(0, 0, 0, 4'hF, 1), '0));
    add_row(mk_row(mk_step(255, 255, 255, 255, 255, 255, 255, 255, 4'hF, 0), 1,
                   mk_hit(1, 255, 255, 4'hF, 1), '0));
    add_row(mk_row(mk_step(9, 9, 9, 9, 9, 9, 9, 9, 4'h0, 0), 0, '0, '0));
    add_row(mk_row(mk_step(0, 0, 0, 0, 255, 255, 255, 255, 4'hF, 0), 2,
                   mk_hit(3, 0, 0, 4'b0011, 0), mk_hit(3, 255, 255, 4'b1100, 1)));
    add_row(mk_row(mk_step(255, 255, 255, 255, 0, 0, 0, 0, 4'hF, 0), 2,
                   mk_hit(4, 0, 0, 4'b1100, 0), mk_hit(4, 255, 255, 4'b0011, 1)));
    add_row(mk_row(mk_step(10, 200, 10, 5, 10, 200, 10, 5, 4'hF, 0), 2,
                   mk_hit(5, 10, 5, 4'b1010, 0), mk_hit(5, 10, 200, 4'b0101, 1)));
    add_row(mk_row(mk_step(7, 7, 7, 7, 8, 7, 7, 7, 4'hF, 0), 1,
                   mk_hit(6, 7, 7, 4'b1011, 1), '0));
    add_row(mk_row(mk_step(0, 255, 255, 0, 1, 254, 254, 1, 4'hF, 0), 0, '0, '0));
    add_row(mk_row(mk_step(3, 3, 3, 3, 4, 4, 4, 4, 4'b1110, 0), 1,
                   mk_hit(8, 4, 4, 4'b1100, 1), '0));
    add_row(mk_row(mk_step(1, 2, 8'hAA, 8'h55, 8'hAA, 8'h55, 3, 4, 4'hF, 1), 1,
                   mk_hit(9, 8'hAA, 8'h55, 4'b0110, 1), '0));
    add_row(mk_row(mk_step(8'h55, 8'hAA, 1, 1, 2, 2, 8'h55, 8'hAA, 4'hF, 0), 1,
                   mk_hit(0, 8'h55, 8'hAA, 4'b1001, 1), '0));
    add_row(mk_row(mk_step(1, 1, 2, 2, 3, 3, 4, 4, 4'hF, 1), 0, '0, '0));
    add_row(mk_row(mk_step(8'hFF, 0, 8'hFF, 0, 1, 1, 2, 2, 4'hF, 1), 1,
                   mk_hit(0, 8'hFF, 0, 4'b0011, 1), '0));
    add_row(mk_row(mk_step(1, 1, 2, 2, 0, 8'hFF, 0, 8'hFF, 4'hF, 0), 1,
                   mk_hit(0, 0, 8'hFF, 4'b1100, 1), '0));
    add_row(mk_row(mk_step(5, 1, 5, 2, 5, 3, 5, 4, 4'hF, 0), -1, '0, '0));
    add_row(mk_row(mk_step(1, 9, 2, 9, 3, 9, 4, 9, 4'hF, 0), -1, '0, '0));
    add_row(mk_row(mk_step(9, 9, 9, 8, 9, 9, 9, 8, 4'hF, 0), -1, '0, '0));
    add_row(mk_row(mk_step(6, 6, 6, 6, 6, 6, 6, 6, 4'b0001, 0), -1, '0, '0));
    add_row(mk_row(mk_step(8'h80, 1, 2, 2, 3, 3, 8'h80, 1, 4'b1001, 0), -1, '0, '0));
    add_row(mk_row(mk_step(8'hFF, 0, 8'hFF, 0, 8'hFF, 0, 8'hFF, 0, 4'b0111, 1),
                   -1, '0, '0));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) drive_step(rows[i]);

    for (int i = 0; i < 1230; i++) begin
      calm = (i >= 500 && i < 750);
      drive_step(rand_row(5, ($urandom_range(99) < 85) ? 80 : 0));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    w = 0;
    while (hit_q.size() != 0 && w < 5000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (20) @(posedge clk_i);
    if (hit_q.size() != 0) begin
      errors++;
      $display("%0d expected reports never arrived", hit_q.size());
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
